@@ rtl/core/hcs_pkg.sv @@
// Shared types, constants and helpers for the hashed chain store core.
// No dependencies; imported by every module of the block.

package hcs_pkg;

   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 13;
   localparam int OUTCOME_W = 3;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam int DEFAULT_TABLE_DEPTH = 4096;
   localparam int DEFAULT_PROBE_LIMIT = 128;

   localparam logic [CFG_W-1:0] TABLE_LENGTH_RESET = 13'd4096;

   // register index, taken from paddr[2]
   localparam logic REG_TABLE_LENGTH = 1'b0;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_STORE  = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUT_MISS     = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_HIT      = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_EVICTED  = 3'd4;

   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [KEY_W-1:0] key_primary;
      logic [KEY_W-1:0] key_secondary;
      logic [VAL_W-1:0] value;
   } hcs_slot_type;

   typedef struct packed {
      logic busy;
      logic done;
   } hcs_mod_stat_type;

   // two's complement word mapped so that unsigned compare gives signed order
   function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v);
      return v ^ {1'b1, {(VAL_W-1){1'b0}}};
   endfunction

endpackage

@@ rtl/core/hcs_mod_unit.sv @@
// Bit-serial remainder unit: key word modulo table length, one bit a cycle.
// Depends on hcs_pkg.

module hcs_mod_unit import hcs_pkg::*; #(
   parameter int LEN_W = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_W-1:0]     dividend,
   input  logic [LEN_W-1:0]     divisor,
   output hcs_mod_stat_type     stat,
   output logic [LEN_W-1:0]     remainder
);

   localparam int CNT_W = $clog2(KEY_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [KEY_W-1:0]  dvd_ff,  dvd_in;
   logic [LEN_W-1:0]  dsr_ff,  dsr_in;
   logic [LEN_W-1:0]  rem_ff,  rem_in;
   logic [LEN_W:0]    trial;
   logic [LEN_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[KEY_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // restoring step: keep the difference when the trial covers the divisor
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[LEN_W-1:0];
         end else begin
            rem_in = trial[LEN_W-1:0];
         end
         dvd_in = {dvd_ff[KEY_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(KEY_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/hashed_chain_store_min_evict_core.sv @@
// Top level of the hashed chain store: slot memory, probe sequencer, CSR port.
// Depends on hcs_pkg and hcs_mod_unit.
//
// Usage
//   Request channel (req_*): one beat carries an opcode (lookup or store), two
//   key words and a Q16.16 value. Taken when req_valid is high and req_stall
//   low. One item is worked on at a time; req_stall stays high until the
//   result beat has been loaded into the output register.
//   Response channel (rsp_*): one beat per request with read value, outcome
//   and the running used-entry count. The output register holds the beat
//   while rsp_stall is high, and the core still takes the next request
//   meanwhile; it only waits at the end of that request if the register is
//   still full.
//   Steps: the bit-serial remainder gives the start slot; the probe then
//   reads one slot a cycle through the single memory read port, over at most
//   span = min(PROBE_LIMIT, length - start) slots, and a store finishes
//   with a write of the chosen slot.
//   Reset: synchronous. Afterwards a clearing pass writes zero to all
//   TABLE_DEPTH slots, one per cycle, with req_stall high; CSR writes are
//   taken throughout. table_length resets to 4096.
//   CSR: table_length at byte address 0; a length of zero acts as 1 and one
//   above TABLE_DEPTH as TABLE_DEPTH. Write only while the core is idle.

module hashed_chain_store_min_evict_core import hcs_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int PROBE_LIMIT = DEFAULT_PROBE_LIMIT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [KEY_W-1:0]            req_key_primary,
   input  logic [KEY_W-1:0]            req_key_secondary,
   input  logic signed [VAL_W-1:0]     req_write_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [VAL_W-1:0]     rsp_read_value,
   output logic [OUTCOME_W-1:0]        rsp_outcome,
   output logic [31:0]                 rsp_used_entries,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_AW-1:0]           csr_paddr,
   input  logic [CSR_DW-1:0]           csr_pwdata,
   output logic [CSR_DW-1:0]           csr_prdata,
   output logic                        csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);      // slot index
   localparam int LW = $clog2(TABLE_DEPTH + 1);  // length, up to TABLE_DEPTH
   localparam int SW = $clog2(PROBE_LIMIT + 1);  // probe count, up to PROBE_LIMIT

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_PROBE,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // slot memory, no reset: cleared by the sweep after reset
   hcs_slot_type mem [TABLE_DEPTH];

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     table_length_ff, table_length_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [LW-1:0]        len_ff, len_in;
   logic                 op_ff, op_in;
   logic [KEY_W-1:0]     k1_ff, k1_in;
   logic [KEY_W-1:0]     k2_ff, k2_in;
   logic [VAL_W-1:0]     wv_ff, wv_in;
   logic [AW-1:0]        start_ff, start_in;
   logic [SW-1:0]        span_ff, span_in;
   logic [SW-1:0]        iss_ff, iss_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   hcs_slot_type         rd_data_ff;
   logic [VAL_W-1:0]     min_ff, min_in;
   logic [AW-1:0]        victim_ff, victim_in;
   logic [AW-1:0]        tgt_ff, tgt_in;
   logic [OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic [VAL_W-1:0]     rv_ff, rv_in;
   logic [31:0]          used_ff, used_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [OUTCOME_W-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic [31:0]          rsp_used_ff, rsp_used_in;

   logic                 accept;
   logic                 csr_write;
   logic [31:0]          tl32;
   logic [31:0]          eff_len32;
   logic [31:0]          diff32;
   logic [31:0]          span32;
   logic [31:0]          addr32;
   logic [AW-1:0]        probe_addr;
   logic                 slot_match;
   logic                 slot_free;
   logic [VAL_W-1:0]     slot_ord;
   logic                 stop;
   logic                 issue;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   hcs_slot_type         mem_wdata;

   hcs_mod_stat_type     mod_stat;
   logic [LW-1:0]        mod_rem;

   hcs_mod_unit #(
      .LEN_W (LW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_key_primary),
      .divisor   (len_in),
      .stat      (mod_stat),
      .remainder (mod_rem)
   );

   assign req_stall = (state_ff != ST_IDLE) || mod_stat.busy;
   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         REG_TABLE_LENGTH: csr_prdata = {{(CSR_DW-CFG_W){1'b0}}, table_length_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // effective length: zero acts as one, saturate at the memory depth
   always_comb begin
      tl32 = 32'(table_length_ff);
      if (tl32 == 32'd0) begin
         eff_len32 = 32'd1;
      end else if (tl32 > 32'(TABLE_DEPTH)) begin
         eff_len32 = 32'(TABLE_DEPTH);
      end else begin
         eff_len32 = tl32;
      end
   end

   // probe span, shortened near the table end
   always_comb begin
      diff32 = 32'(len_ff) - 32'(mod_rem);
      if (diff32 > 32'(PROBE_LIMIT)) begin
         span32 = 32'(PROBE_LIMIT);
      end else begin
         span32 = diff32;
      end
   end

   assign addr32     = 32'(start_ff) + 32'(iss_ff);
   assign probe_addr = addr32[AW-1:0];
   assign slot_match = (rd_data_ff.key_primary == k1_ff) &&
                       (rd_data_ff.key_secondary == k2_ff);
   assign slot_free  = (rd_data_ff.key_primary == '0) &&
                       (rd_data_ff.key_secondary == '0);
   assign slot_ord   = order_key(rd_data_ff.value);
   assign stop       = rd_vld_ff && (slot_match || (op_ff == OP_STORE && slot_free));
   assign issue      = (state_ff == ST_PROBE) && !stop && (iss_ff < span_ff);

   always_comb begin
      state_in        = state_ff;
      table_length_in = table_length_ff;
      clr_in          = clr_ff;
      len_in          = len_ff;
      op_in           = op_ff;
      k1_in           = k1_ff;
      k2_in           = k2_ff;
      wv_in           = wv_ff;
      start_in        = start_ff;
      span_in         = span_ff;
      iss_in          = iss_ff;
      rd_vld_in       = 1'b0;
      rd_addr_in      = rd_addr_ff;
      min_in          = min_ff;
      victim_in       = victim_ff;
      tgt_in          = tgt_ff;
      outcome_in      = outcome_ff;
      rv_in           = rv_ff;
      used_in         = used_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_value_in    = rsp_value_ff;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_used_in     = rsp_used_ff;
      mem_we          = 1'b0;
      mem_waddr       = tgt_ff;
      mem_wdata       = '{key_primary: k1_ff, key_secondary: k2_ff, value: wv_ff};

      if (csr_write && csr_paddr[2] == REG_TABLE_LENGTH) begin
         table_length_in = csr_pwdata[CFG_W-1:0];
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            len_in = eff_len32[LW-1:0];
            if (accept) begin
               op_in    = req_opcode;
               k1_in    = req_key_primary;
               k2_in    = req_key_secondary;
               wv_in    = req_write_value;
               iss_in   = '0;
               min_in   = order_key(VAL_MAX);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_stat.done) begin
               start_in  = mod_rem[AW-1:0];
               victim_in = mod_rem[AW-1:0];
               span_in   = span32[SW-1:0];
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (issue) begin
               iss_in     = iss_ff + 1'b1;
               rd_vld_in  = 1'b1;
               rd_addr_in = probe_addr;
            end
            if (rd_vld_ff) begin
               if (slot_match) begin
                  outcome_in = (op_ff == OP_STORE) ? OUT_UPDATED : OUT_HIT;
                  rv_in      = (op_ff == OP_STORE) ? '0 : rd_data_ff.value;
                  tgt_in     = rd_addr_ff;
                  state_in   = ST_FINISH;
               end else if (op_ff == OP_STORE && slot_free) begin
                  outcome_in = OUT_INSERTED;
                  rv_in      = '0;
                  tgt_in     = rd_addr_ff;
                  state_in   = ST_FINISH;
               end else if (op_ff == OP_STORE && slot_ord < min_ff) begin
                  min_in    = slot_ord;
                  victim_in = rd_addr_ff;
               end
            end else if (iss_ff == span_ff) begin
               // chain exhausted: miss, or evict the smallest value seen
               outcome_in = (op_ff == OP_STORE) ? OUT_EVICTED : OUT_MISS;
               rv_in      = '0;
               tgt_in     = victim_ff;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (op_ff == OP_STORE) begin
               mem_we = 1'b1;
            end
            if (outcome_ff == OUT_INSERTED) begin
               used_in = used_ff + 32'd1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = rv_ff;
               rsp_outcome_in = outcome_ff;
               rsp_used_in    = used_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         table_length_ff <= TABLE_LENGTH_RESET;
         clr_ff          <= '0;
         rd_vld_ff       <= 1'b0;
         used_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         table_length_ff <= table_length_in;
         clr_ff          <= clr_in;
         rd_vld_ff       <= rd_vld_in;
         used_ff         <= used_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      len_ff         <= len_in;
      op_ff          <= op_in;
      k1_ff          <= k1_in;
      k2_ff          <= k2_in;
      wv_ff          <= wv_in;
      start_ff       <= start_in;
      span_ff        <= span_in;
      iss_ff         <= iss_in;
      rd_addr_ff     <= rd_addr_in;
      min_ff         <= min_in;
      victim_ff      <= victim_in;
      tgt_ff         <= tgt_in;
      outcome_ff     <= outcome_in;
      rv_ff          <= rv_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_used_ff    <= rsp_used_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[probe_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_used_entries = rsp_used_ff;

endmodule

@@ rtl/core/hcs_port_checker.sv @@
// Port-level assertions for the hashed chain store core, bound to the top level.
// Depends on hcs_pkg and hashed_chain_store_min_evict_core.

module hcs_port_checker import hcs_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [VAL_W-1:0]        rsp_read_value,
   input logic [OUTCOME_W-1:0]    rsp_outcome,
   input logic [31:0]             rsp_used_entries,
   input logic                    csr_psel,
   input logic                    csr_penable,
   input logic                    csr_pwrite,
   input logic [CSR_AW-1:0]       csr_paddr,
   input logic [CSR_DW-1:0]       csr_pwdata,
   input logic [CSR_DW-1:0]       csr_prdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value) &&
                                 $stable(rsp_outcome) && $stable(rsp_used_entries))
      else $error("stalled response beat changed");

   // one item at a time: busy straight after taking a request
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // only a lookup hit carries a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OUT_HIT |-> rsp_read_value == '0)
      else $error("non-zero value on miss or store");

   // table_length readback follows a write
   a_csr_rb: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_TABLE_LENGTH
      |=> csr_prdata[CFG_W-1:0] == $past(csr_pwdata[CFG_W-1:0]) ||
          csr_paddr[2] != REG_TABLE_LENGTH)
      else $error("table_length readback mismatch");

endmodule

bind hashed_chain_store_min_evict_core hcs_port_checker u_hcs_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_read_value   (rsp_read_value),
   .rsp_outcome      (rsp_outcome),
   .rsp_used_entries (rsp_used_entries),
   .csr_psel         (csr_psel),
   .csr_penable      (csr_penable),
   .csr_pwrite       (csr_pwrite),
   .csr_paddr        (csr_paddr),
   .csr_pwdata       (csr_pwdata),
   .csr_prdata       (csr_prdata)
);

@@ verif/hcs_store_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the hashed chain store: snoops request, reply and CSR traffic,
// keeps its own slot table and checks every reply beat. Depends on hcs_pkg.

module hcs_store_checker import hcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_opcode,
   input  logic [KEY_W-1:0]        req_key_primary,
   input  logic [KEY_W-1:0]        req_key_secondary,
   input  logic signed [VAL_W-1:0] req_write_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [VAL_W-1:0] rsp_read_value,
   input  logic [OUTCOME_W-1:0]    rsp_outcome,
   input  logic [31:0]             rsp_used_entries,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_AW-1:0]       csr_paddr,
   input  logic [CSR_DW-1:0]       csr_pwdata,
   input  logic [CSR_DW-1:0]       csr_prdata,
   input  logic                    csr_pready,
   output int                      fail_count,
   output int                      pending
);

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int CHAIN = DEFAULT_PROBE_LIMIT;

   typedef struct {
      logic signed [VAL_W-1:0] read_value;
      logic [OUTCOME_W-1:0]    outcome;
      logic [31:0]             used;
   } reply_type;

   logic [KEY_W-1:0] tab_kp  [DEPTH];
   logic [KEY_W-1:0] tab_ks  [DEPTH];
   logic [VAL_W-1:0] tab_val [DEPTH];
   logic [31:0]      used_total;
   logic [CFG_W-1:0] cfg_length;

   reply_type due_replies[$];
   reply_type head;

   // one access against the shadow table; returns the reply it should produce
   function automatic reply_type apply_access(input logic op, input logic [KEY_W-1:0] kp,
                                              input logic [KEY_W-1:0] ks,
                                              input logic [VAL_W-1:0] wv);
      int unsigned len, start, span, s, victim;
      logic        done, have_victim;
      logic [VAL_W-1:0] least;
      reply_type r;
      len = cfg_length;
      if (len == 0) len = 1;
      if (len > DEPTH) len = DEPTH;
      start = kp % len;
      span  = len - start;
      if (span > CHAIN) span = CHAIN;
      r.read_value = '0;
      done = 1'b0;
      if (op == OP_LOOKUP) begin
         r.outcome = OUT_MISS;
         for (int i = 0; i < span && !done; i++) begin
            s = start + i;
            if (tab_kp[s] == kp && tab_ks[s] == ks) begin
               r.read_value = tab_val[s];
               r.outcome    = OUT_HIT;
               done         = 1'b1;
            end
         end
      end else begin
         r.outcome   = OUT_EVICTED;
         have_victim = 1'b0;
         victim      = start;
         least       = VAL_MAX;
         for (int i = 0; i < span && !done; i++) begin
            s = start + i;
            if (tab_kp[s] == kp && tab_ks[s] == ks) begin
               tab_val[s] = wv;
               r.outcome  = OUT_UPDATED;
               done       = 1'b1;
            end else if (tab_kp[s] == '0 && tab_ks[s] == '0) begin
               tab_kp[s]  = kp;
               tab_ks[s]  = ks;
               tab_val[s] = wv;
               used_total = used_total + 1;
               r.outcome  = OUT_INSERTED;
               done       = 1'b1;
            end else if ($signed(tab_val[s]) < $signed(least)) begin
               least       = tab_val[s];
               victim      = s;
               have_victim = 1'b1;
            end
         end
         if (!done) begin
            if (!have_victim) victim = start;
            tab_kp[victim]  = kp;
            tab_ks[victim]  = ks;
            tab_val[victim] = wv;
         end
      end
      r.used = used_total;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tab_kp[i]  = '0;
            tab_ks[i]  = '0;
            tab_val[i] = '0;
         end
         used_total = '0;
         cfg_length = TABLE_LENGTH_RESET;
         due_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               $error("reply beat with nothing outstanding: outcome %0d", rsp_outcome);
               fail_count++;
            end else begin
               head = due_replies.pop_front();
               if (rsp_read_value !== head.read_value) begin
                  $error("read_value: expected %h, got %h", head.read_value, rsp_read_value);
                  fail_count++;
               end
               if (rsp_outcome !== head.outcome) begin
                  $error("outcome: expected %0d, got %0d", head.outcome, rsp_outcome);
                  fail_count++;
               end
               if (rsp_used_entries !== head.used) begin
                  $error("used_entries: expected %0d, got %0d", head.used, rsp_used_entries);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            due_replies.push_back(apply_access(req_opcode, req_key_primary,
                                               req_key_secondary, req_write_value));
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == REG_TABLE_LENGTH) begin
            if (csr_pwrite)
               cfg_length = csr_pwdata[CFG_W-1:0];
            else if (csr_prdata !== CSR_DW'(cfg_length)) begin
               $error("table_length: expected %0d, got %0d", cfg_length, csr_prdata);
               fail_count++;
            end
         end
      end
      pending <= due_replies.size();
   end

endmodule

@@ verif/tb_hashed_chain_store_min_evict_core.sv @@
`timescale 1ns / 100ps
// Regression top for the hashed chain store core: clock, reset, request and
// CSR stimulus, reply back-pressure. Depends on hcs_pkg, the core and hcs_store_checker.

module tb_hashed_chain_store_min_evict_core import hcs_pkg::*;;

   localparam int          HOLD_CYCLES = 600;   // one long receiver hold-off
   localparam int          HOLD_AFTER  = 200;   // replies seen before the hold starts
   localparam int          PHASE_ITEMS = 125;
   localparam int          POOL_SIZE   = 48;
   localparam logic [CSR_AW-1:0] LEN_ADDR = {REG_TABLE_LENGTH, 2'b00};
   localparam logic [VAL_W-1:0]  VAL_MIN  = 32'h8000_0000;

   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic                    req_opcode        = OP_LOOKUP;
   logic [KEY_W-1:0]        req_key_primary   = '0;
   logic [KEY_W-1:0]        req_key_secondary = '0;
   logic signed [VAL_W-1:0] req_write_value   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic [OUTCOME_W-1:0]    rsp_outcome;
   logic [31:0]             rsp_used_entries;
   logic                    csr_psel          = 1'b0;
   logic                    csr_penable       = 1'b0;
   logic                    csr_pwrite        = 1'b0;
   logic [CSR_AW-1:0]       csr_paddr         = '0;
   logic [CSR_DW-1:0]       csr_pwdata        = '0;
   logic [CSR_DW-1:0]       csr_prdata;
   logic                    csr_pready;

   int  fail_count;
   int  pending;
   int  sent       = 0;
   int  rsp_seen   = 0;
   int  n_settings = 0;
   bit  quiet      = 1'b0;   // no gaps and no stalls while set
   bit  hold_done  = 1'b0;

   // key pairs already offered, reused so that hits, updates and chains occur
   logic [KEY_W-1:0] pool_kp [POOL_SIZE];
   logic [KEY_W-1:0] pool_ks [POOL_SIZE];
   int               pool_n = 0;

   // table lengths walked by the random part; 0 and 8191 hit the clamps
   int lens [12] = '{16, 4096, 5, 1, 64, 0, 8191, 3, 200, 32, 4096, 9};

   hashed_chain_store_min_evict_core dut (.*);

   hcs_store_checker chk (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_key_primary, .req_key_secondary,
      .req_write_value,
      .rsp_valid, .rsp_stall, .rsp_read_value, .rsp_outcome, .rsp_used_entries,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata,
      .csr_pready,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // generous cap: clearing pass plus every access at full chain and worst idling
   initial begin
      #60_000_000;
      $display("hashed_chain_store_min_evict_core regression: fail");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) rsp_seen <= rsp_seen + 1;

   // mostly short idles, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // Reply side back-pressure. Free and stalled stretches alternate; once, after
   // HOLD_AFTER replies, the stall is held for HOLD_CYCLES so the core backs up
   // and stalls its own input while the sender keeps offering.
   initial begin
      int unsigned stall_len, run;
      forever begin
         if (!hold_done && rsp_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            stall_len = quiet ? 0 : pick_gap();
            run       = $urandom_range(1, 12);
            @(negedge clock) rsp_stall <= 1'b0;
            repeat (run - 1) @(negedge clock);
            if (stall_len != 0) begin
               @(negedge clock) rsp_stall <= 1'b1;
               repeat (stall_len - 1) @(negedge clock);
            end
         end
      end
   end

   // one request beat; payload held until taken, then an optional gap
   task automatic send_item(input logic op, input logic [KEY_W-1:0] kp,
                            input logic [KEY_W-1:0] ks, input logic [VAL_W-1:0] wv);
      int unsigned gap;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_key_primary   <= kp;
      req_key_secondary <= ks;
      req_write_value   <= wv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // APB setup + access; pready is waited on though the core ties it high
   task automatic csr_access(input logic wr, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= LEN_ADDR;
      csr_pwdata  <= data;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_length(input int len);
      csr_access(1'b1, CSR_DW'(len));
      csr_access(1'b0, '0);   // read-back, checked by the scoreboard
      n_settings++;
   endtask

   // drop valid so the last beat is not taken twice, then wait for every reply
   task automatic wait_drained();
      @(negedge clock) req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Random access. Most keys come from the pool, so small tables fill up and
   // start evicting; the rest are fresh, all-zero or half-zero key pairs.
   task automatic random_item();
      int unsigned r, idx;
      logic             op;
      logic [KEY_W-1:0] kp, ks;
      logic [VAL_W-1:0] wv;
      op = ($urandom_range(0, 99) < 55) ? OP_STORE : OP_LOOKUP;
      r  = $urandom_range(0, 99);
      if (r < 60 && pool_n > 0) begin
         idx = $urandom_range(0, pool_n - 1);
         kp  = pool_kp[idx];
         ks  = pool_ks[idx];
      end else if (r < 65) begin
         kp = '0;
         ks = '0;
      end else if (r < 70) begin
         kp = $urandom_range(0, 1) ? $urandom : '0;
         ks = (kp == '0) ? $urandom : '0;
      end else begin
         kp = $urandom;
         ks = $urandom;
         if (pool_n < POOL_SIZE) begin
            idx = pool_n;
            pool_n++;
         end else begin
            idx = $urandom_range(0, POOL_SIZE - 1);
         end
         pool_kp[idx] = kp;
         pool_ks[idx] = ks;
      end
      r = $urandom_range(0, 99);
      if (r < 70)      wv = $urandom;
      else if (r < 80) wv = VAL_MAX;
      else if (r < 90) wv = VAL_MIN;
      else             wv = VAL_W'($signed(9'($urandom_range(0, 511))));
      send_item(op, kp, ks, wv);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // ---- directed part ----------------------------------------------
      // two slots: zero keys as an ordinary match, fill, then eviction with
      // every probed value at the maximum (falls back to the start slot)
      set_length(2);
      send_item(OP_LOOKUP, 32'd0, 32'd0, 32'd0);          // zero keys hit a free slot
      send_item(OP_STORE,  32'd0, 32'd0, 32'd5);          // ... and update it, no count
      send_item(OP_STORE,  32'd2, 32'hFFFF_FFFF, VAL_MAX);
      send_item(OP_STORE,  32'd4, 32'd1, VAL_MAX);        // table now full, all at max
      send_item(OP_STORE,  32'd6, 32'd2, VAL_MIN);        // no victim below max
      send_item(OP_LOOKUP, 32'd6, 32'd2, 32'd0);
      send_item(OP_LOOKUP, 32'd2, 32'hFFFF_FFFF, 32'd0);  // evicted, now a miss
      send_item(OP_STORE,  32'd1, 32'd3, 32'h1234_5678);  // start at last slot, span 1
      send_item(OP_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_STORE,  32'd6, 32'd2, VAL_MAX);        // update
      send_item(OP_LOOKUP, 32'd4, 32'd1, 32'd0);

      // zero length acts as one slot; entries beyond it stay put but unseen
      wait_drained();
      set_length(0);
      send_item(OP_STORE,  32'h8000_0000, 32'd7, 32'd100);
      send_item(OP_LOOKUP, 32'h8000_0000, 32'd7, 32'd0);
      send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);

      // largest register value saturates to the full depth; probe cut at the end
      wait_drained();
      set_length(8191);
      send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_STORE,  32'd4095, 32'd9, VAL_MAX);
      send_item(OP_LOOKUP, 32'd4095, 32'd9, 32'd0);
      send_item(OP_STORE,  32'd4097, 32'd0, 32'd0);
      send_item(OP_LOOKUP, 32'd1, 32'd3, 32'd0);

      // ---- random part, one length setting per phase -------------------
      foreach (lens[p]) begin
         wait_drained();
         set_length(lens[p]);
         quiet = (p == 3 || p == 7);
         repeat (PHASE_ITEMS) random_item();
      end
      quiet = 1'b0;

      @(negedge clock) req_valid <= 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);   // catch stray reply beats

      $display("covered %0d accesses, %0d replies, over %0d table length settings",
               sent, rsp_seen, n_settings);
      $display("with random idling on both sides and one %0d-cycle reply hold-off",
               HOLD_CYCLES);
      if (fail_count == 0 && pending == 0)
         $display("hashed_chain_store_min_evict_core regression: pass");
      else
         $display("hashed_chain_store_min_evict_core regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/hcs_pkg.sv
rtl/core/hcs_mod_unit.sv
rtl/core/hashed_chain_store_min_evict_core.sv
rtl/core/hcs_port_checker.sv
verif/hcs_store_checker.sv
verif/tb_hashed_chain_store_min_evict_core.sv
